// ----- src/m3inv_pkg.sv -----
package m3inv_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_ELEMS = 9;

endpackage

// ----- src/matrix3x3_inverse.sv -----
// Path from input transfer to result valid: five product/cofactor/determinant stages,
// the divider input stage, ELEM_WIDTH + 1 quotient stages and the output register.
// Throughput: one matrix per cycle while req_stall is low; the nine divider lanes are
// bit-per-stage pipelines. A stalled result holds the output register; the pipeline
// keeps moving unless its last stage holds a result while the output register is held.
// Reset: synchronous, active high; clears valids.
module matrix3x3_inverse #(
   parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ELEM_WIDTH-1:0] req_a00, req_a01, req_a02,
   input  logic signed [ELEM_WIDTH-1:0] req_a10, req_a11, req_a12,
   input  logic signed [ELEM_WIDTH-1:0] req_a20, req_a21, req_a22,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [ELEM_WIDTH-1:0] rsp_b00, rsp_b01, rsp_b02,
   output logic signed [ELEM_WIDTH-1:0] rsp_b10, rsp_b11, rsp_b12,
   output logic signed [ELEM_WIDTH-1:0] rsp_b20, rsp_b21, rsp_b22,
   output logic                         rsp_singular,
   output logic                         rsp_overflow
);
   localparam int NE  = m3inv_pkg::NUM_ELEMS;
   localparam int DW  = 3 * ELEM_WIDTH + 3;
   localparam int LAT = 5 + ELEM_WIDTH + 2;   // pipeline stages ahead of the output register
   localparam int SL  = LAT - 5;              // stages from divider input to the end

   logic signed [ELEM_WIDTH-1:0] m [NE];
   logic signed [2*ELEM_WIDTH+1:0] cof [NE];
   logic signed [DW-1:0] det;
   logic [DW-1:0] dmag;
   logic en;
   logic out_ld;

   logic [LAT-1:0] vld_ff;
   logic [SL-1:0]  sng_ff;
   logic           out_vld_ff;

   assign m = '{req_a00, req_a01, req_a02, req_a10, req_a11, req_a12,
                req_a20, req_a21, req_a22};

   assign out_ld = !out_vld_ff || !rsp_stall;
   // pipeline moves unless its last stage holds a result the output register cannot take
   assign en = out_ld || !vld_ff[LAT-1];
   assign req_stall = !en;

   m3inv_adj #(.ELEM_WIDTH(ELEM_WIDTH)) u_adj (
      .clock (clock), .en (en), .m (m), .cof (cof), .det (det)
   );

   assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

   logic [ELEM_WIDTH-1:0] res [NE];
   logic [NE-1:0]         ovf;
   for (genvar i = 0; i < NE; i++) begin : g_lane
      m3inv_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock), .en (en), .cof (cof[i]),
         .dmag (det == '0 ? DW'(1) : dmag), .dneg (det[DW-1]),
         .res (res[i]), .ovf (ovf[i])
      );
   end

   // singular flag joins at the divider input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sng_ff <= {sng_ff[SL-2:0], det == '0};
      end
   end

   // merge stage: output register
   logic [ELEM_WIDTH-1:0] b_ff [NE];
   logic                  sng_o_ff, ovf_o_ff;
   logic                  sng;
   assign sng = sng_ff[SL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ld) begin
         out_vld_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ld) begin
         for (int i = 0; i < NE; i++) begin
            b_ff[i] <= sng ? '0 : res[i];
         end
         sng_o_ff <= sng;
         ovf_o_ff <= !sng && (|ovf);
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_b00 = b_ff[0]; assign rsp_b01 = b_ff[1]; assign rsp_b02 = b_ff[2];
   assign rsp_b10 = b_ff[3]; assign rsp_b11 = b_ff[4]; assign rsp_b12 = b_ff[5];
   assign rsp_b20 = b_ff[6]; assign rsp_b21 = b_ff[7]; assign rsp_b22 = b_ff[8];
   assign rsp_singular = sng_o_ff;
   assign rsp_overflow = ovf_o_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_singular && rsp_overflow))
      else $error("singular and overflow together");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");
endmodule

// ----- src/m3inv_adj.sv -----
// Product, cofactor and determinant stages: nine cofactors and the determinant.
module m3inv_adj #(
   parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [ELEM_WIDTH-1:0]      m [9],
   output logic signed [2*ELEM_WIDTH+1:0]    cof [9],
   output logic signed [3*ELEM_WIDTH+2:0]    det
);
   localparam int PW  = 2 * ELEM_WIDTH;
   localparam int CW  = 2 * ELEM_WIDTH + 2;
   localparam int DW  = 3 * ELEM_WIDTH + 3;
   localparam int LB  = ELEM_WIDTH + 1;        // low cofactor slice, unsigned
   localparam int HW  = CW - LB;               // high cofactor slice, signed
   localparam int LPW = LB + 1 + ELEM_WIDTH;
   localparam int HPW = HW + ELEM_WIDTH;

   logic signed [PW-1:0] p_ff [18];
   logic signed [PW-1:0] p_in [18];
   logic signed [ELEM_WIDTH-1:0] mr_ff [3];
   logic signed [CW-1:0] cof_ff [9];
   logic signed [CW-1:0] cof_in [9];
   logic signed [ELEM_WIDTH-1:0] mr2_ff [3];
   logic signed [LPW-1:0] pl_ff [3];
   logic signed [LPW-1:0] pl_in [3];
   logic signed [HPW-1:0] ph_ff [3];
   logic signed [HPW-1:0] ph_in [3];
   logic signed [DW-1:0] dp_ff [3];
   logic signed [DW-1:0] dp_in [3];
   logic signed [DW-1:0] det_ff;
   logic signed [DW-1:0] det_in;
   logic signed [CW-1:0] cof3_ff [9];
   logic signed [CW-1:0] cof4_ff [9];
   logic signed [CW-1:0] cof5_ff [9];

   // stage 1: 18 products
   always_comb begin
      p_in[0]  = m[4] * m[8];  p_in[1]  = m[7] * m[5];
      p_in[2]  = m[7] * m[2];  p_in[3]  = m[1] * m[8];
      p_in[4]  = m[1] * m[5];  p_in[5]  = m[4] * m[2];
      p_in[6]  = m[6] * m[5];  p_in[7]  = m[3] * m[8];
      p_in[8]  = m[0] * m[8];  p_in[9]  = m[6] * m[2];
      p_in[10] = m[3] * m[2];  p_in[11] = m[0] * m[5];
      p_in[12] = m[3] * m[7];  p_in[13] = m[6] * m[4];
      p_in[14] = m[6] * m[1];  p_in[15] = m[0] * m[7];
      p_in[16] = m[0] * m[4];  p_in[17] = m[3] * m[1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
         mr_ff[0] <= m[2];
         mr_ff[1] <= m[5];
         mr_ff[2] <= m[8];
      end
   end

   // stage 2: cofactors
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         cof_in[i] = CW'(p_ff[2*i]) - CW'(p_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cof_ff <= cof_in;
         mr2_ff <= mr_ff;
      end
   end

   // stage 3: bottom row cofactors times column 2, split into low and high halves
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pl_in[i] = LPW'($signed({1'b0, cof_ff[6+i][LB-1:0]})) * LPW'(mr2_ff[i]);
         ph_in[i] = HPW'($signed(cof_ff[6+i][CW-1:LB])) * HPW'(mr2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff <= pl_in;
         ph_ff <= ph_in;
         cof3_ff <= cof_ff;
      end
   end

   // stage 4: recombine the halves
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dp_in[i] = (DW'(ph_ff[i]) <<< LB) + DW'(pl_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp_ff <= dp_in;
         cof4_ff <= cof3_ff;
      end
   end

   // stage 5: determinant
   assign det_in = dp_ff[0] + dp_ff[1] + dp_ff[2];

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= det_in;
         cof5_ff <= cof4_ff;
      end
   end

   assign cof = cof5_ff;
   assign det = det_ff;
endmodule

// ----- src/m3inv_div.sv -----
// One divider lane: pipelined restoring division, one quotient bit per stage.
module m3inv_div #(
   parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [2*ELEM_WIDTH+1:0]  cof,
   input  logic        [3*ELEM_WIDTH+2:0]  dmag,   // |det|, nonzero
   input  logic                            dneg,
   output logic        [ELEM_WIDTH-1:0]    res,
   output logic                            ovf
);
   localparam int CW = 2 * ELEM_WIDTH + 2;
   localparam int DW = 3 * ELEM_WIDTH + 3;
   localparam int QB = ELEM_WIDTH + 1;          // quotient bits kept
   localparam int RW = DW + 2;                  // remainder width
   localparam int NW = CW + 2 * FRAC_BITS + 1;  // scaled numerator width
   localparam int XW = NW + 1;

   logic [XW-1:0] num;
   logic [RW-1:0] den2;
   logic          big_q;   // quotient certainly beyond the kept bits

   logic [CW-1:0] cmag;
   assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);
   // numerator = 2*|c|*2^(2F) + |d|, divisor = 2*|d|
   assign num  = (XW'(cmag) << (2 * FRAC_BITS + 1)) + XW'(dmag);
   assign den2 = {1'b0, dmag, 1'b0};

   // the high part of the numerator above QB quotient bits: compare once
   logic [XW-1:0] den_sh;
   logic [XW+RW-1:0] hi_cmp;
   assign hi_cmp = (XW+RW)'(den2) << QB;
   assign big_q  = (XW+RW)'(num) >= hi_cmp;
   assign den_sh = '0;

   logic [RW-1:0] rem_ff [QB+1];
   logic [XW-1:0] n_ff   [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic [RW-1:0] d_ff   [QB+1];
   logic          neg_ff [QB+1];
   logic          big_ff [QB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(num >> QB);
         n_ff[0]   <= num | den_sh;
         q_ff[0]   <= '0;
         d_ff[0]   <= den2;
         neg_ff[0] <= cof[CW-1] ^ dneg;
         big_ff[0] <= big_q;
      end
   end

   for (genvar s = 0; s < QB; s++) begin : g_stage
      logic [RW-1:0] r_sh;
      logic [RW:0]   diff;
      assign r_sh = {rem_ff[s][RW-2:0], n_ff[s][QB-1-s]};
      assign diff = {1'b0, r_sh} - {1'b0, d_ff[s]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= diff[RW] ? r_sh : diff[RW-1:0];
            q_ff[s+1]   <= {q_ff[s][QB-2:0], ~diff[RW]};
            n_ff[s+1]   <= n_ff[s];
            d_ff[s+1]   <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            big_ff[s+1] <= big_ff[s];
         end
      end
   end

   logic [QB-1:0] q;
   logic          neg;
   logic [QB-1:0] lim;
   assign q   = q_ff[QB];
   assign neg = neg_ff[QB];
   assign lim = neg ? (QB'(1) << (ELEM_WIDTH - 1)) : ((QB'(1) << (ELEM_WIDTH - 1)) - QB'(1));

   always_comb begin
      if (big_ff[QB] || q > lim) begin
         ovf = 1'b1;
         res = neg ? ELEM_WIDTH'(-lim) : lim[ELEM_WIDTH-1:0];
      end else begin
         ovf = 1'b0;
         res = neg ? ELEM_WIDTH'(-q) : q[ELEM_WIDTH-1:0];
      end
   end
endmodule
